/* src/mts_pkg.sv */
package mts_pkg;

   localparam int ENTITY_MAX = 4;
   localparam int LEN_W = $clog2(ENTITY_MAX + 2);
   localparam int IDX_W = $clog2(ENTITY_MAX);
   localparam int NUM_ENTITIES = 6;
   localparam int NAME_MAX = 4;

   localparam logic [7:0] CH_LT   = 8'h3C;
   localparam logic [7:0] CH_GT   = 8'h3E;
   localparam logic [7:0] CH_AMP  = 8'h26;
   localparam logic [7:0] CH_SEMI = 8'h3B;
   localparam logic [7:0] CH_CR   = 8'h0D;
   localparam logic [7:0] CH_LF   = 8'h0A;
   localparam logic [7:0] CH_TAB  = 8'h09;
   localparam logic [7:0] CH_SPC  = 8'h20;

   localparam logic [LEN_W-1:0] LEN_OVERFLOW = LEN_W'(ENTITY_MAX + 1);

   typedef logic [ENTITY_MAX-1:0][7:0] mts_name_type;

   typedef struct packed {
      logic [2:0]                len;
      logic [NAME_MAX-1:0][7:0]  name;
      logic [7:0]                value;
   } mts_entity_type;

   // Names are stored with the first character in element 0.
   localparam mts_entity_type KNOWN_ENTITIES [NUM_ENTITIES] = '{
      '{3'd3, {8'h00, "p", "m", "a"}, CH_AMP},
      '{3'd2, {8'h00, 8'h00, "t", "l"}, CH_LT},
      '{3'd2, {8'h00, 8'h00, "t", "g"}, CH_GT},
      '{3'd4, {"p", "s", "b", "n"}, CH_SPC},
      '{3'd4, {"t", "o", "u", "q"}, 8'h22},
      '{3'd4, {"s", "o", "p", "a"}, 8'h27}
   };

   typedef struct packed {
      logic       valid;
      logic [7:0] ch;
   } mts_char_type;

   typedef struct packed {
      logic       clear;
      logic       valid;
      logic [7:0] ch;
   } mts_token_type;

   function automatic mts_char_type mts_decode(mts_name_type chars, logic [LEN_W-1:0] len);
      mts_char_type res;
      logic same;
      res = '0;
      for (int k = 0; k < NUM_ENTITIES; k++) begin
         same = (len == LEN_W'(KNOWN_ENTITIES[k].len));
         for (int i = 0; i < NAME_MAX; i++) begin
            if (i < int'(KNOWN_ENTITIES[k].len) && chars[i] != KNOWN_ENTITIES[k].name[i]) begin
               same = 1'b0;
            end
         end
         if (same && !res.valid) begin
            res.valid = 1'b1;
            res.ch = KNOWN_ENTITIES[k].value;
         end
      end
      return res;
   endfunction

endpackage

/* src/mts_req_if.sv */
interface mts_req_if;
   logic       valid;
   logic       ready;
   logic       start_of_text;
   logic [7:0] in_byte;

   modport source (output valid, output start_of_text, output in_byte, input ready);
   modport sink (input valid, input start_of_text, input in_byte, output ready);
endinterface

/* src/mts_rsp_if.sv */
interface mts_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;

   modport source (output valid, output out_byte, input ready);
   modport sink (input valid, input out_byte, output ready);
endinterface

/* src/mts_parse.sv */
module mts_parse (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  step,
   input  logic                  start_of_text,
   input  logic [7:0]            in_byte,
   output mts_pkg::mts_token_type token
);
   import mts_pkg::*;

   logic               inside_tag_ff, inside_tag_in;
   logic               inside_entity_ff, inside_entity_in;
   logic [LEN_W-1:0]   entity_length_ff, entity_length_in;
   mts_name_type       entity_chars_ff, entity_chars_in;

   logic               tag_cur;
   logic               entity_cur;
   logic [LEN_W-1:0]   length_cur;
   mts_char_type       decoded;

   // A start flag makes this byte see the cleared state.
   assign tag_cur    = start_of_text ? 1'b0 : inside_tag_ff;
   assign entity_cur = start_of_text ? 1'b0 : inside_entity_ff;
   assign length_cur = start_of_text ? '0 : entity_length_ff;
   assign decoded    = mts_decode(entity_chars_ff, length_cur);

   always_comb begin
      inside_tag_in    = tag_cur;
      inside_entity_in = entity_cur;
      entity_length_in = length_cur;
      entity_chars_in  = entity_chars_ff;
      token.clear      = start_of_text;
      token.valid      = 1'b0;
      token.ch         = in_byte;
      if (in_byte == CH_LT) begin
         inside_tag_in = 1'b1;
      end else if (in_byte == CH_GT) begin
         inside_tag_in = 1'b0;
      end else if (tag_cur) begin
         inside_tag_in = 1'b1;
      end else if (in_byte == CH_AMP) begin
         inside_entity_in = 1'b1;
         entity_length_in = '0;
      end else if (entity_cur) begin
         if (in_byte == CH_SEMI) begin
            inside_entity_in = 1'b0;
            token.valid      = decoded.valid;
            token.ch         = decoded.ch;
         end else if (length_cur < LEN_W'(ENTITY_MAX)) begin
            entity_chars_in[length_cur[IDX_W-1:0]] = in_byte;
            entity_length_in = length_cur + LEN_W'(1);
         end else begin
            entity_length_in = LEN_OVERFLOW;
         end
      end else begin
         token.valid = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         inside_tag_ff    <= 1'b0;
         inside_entity_ff <= 1'b0;
         entity_length_ff <= '0;
      end else if (step) begin
         inside_tag_ff    <= inside_tag_in;
         inside_entity_ff <= inside_entity_in;
         entity_length_ff <= entity_length_in;
      end
   end

   // Only characters below the current length are ever compared.
   always_ff @(posedge clock) begin
      if (step) begin
         entity_chars_ff <= entity_chars_in;
      end
   end

endmodule

/* src/mts_collapse.sv */
module mts_collapse (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  step,
   input  mts_pkg::mts_token_type token,
   output mts_pkg::mts_char_type  result
);
   import mts_pkg::*;

   logic after_space_ff, after_space_in;
   logic space_cur;

   assign space_cur = token.clear ? 1'b0 : after_space_ff;

   always_comb begin
      after_space_in = space_cur;
      result.valid   = 1'b0;
      result.ch      = token.ch;
      if (token.valid) begin
         if (token.ch == CH_CR) begin
            result.valid = 1'b0;
         end else if (token.ch == CH_SPC || token.ch == CH_TAB) begin
            result.valid   = !space_cur;
            result.ch      = CH_SPC;
            after_space_in = 1'b1;
         end else begin
            result.valid   = 1'b1;
            after_space_in = (token.ch == CH_LF);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         after_space_ff <= 1'b0;
      end else if (step) begin
         after_space_ff <= after_space_in;
      end
   end

endmodule

/* src/markup_tag_stripper_unit.sv */
// Channel   Direction  Payload                      Handshake
// req_bus   in         start_of_text, in_byte       valid/ready
// rsp_bus   out        out_byte                     valid/ready
//
// A request is taken into the input register and processed there against the parse state.
// Its plain-text byte (if any) is loaded into the output register as that request steps out,
// so the response is registered; one request per cycle is sustained while rsp_bus is ready.
// The input register advances whenever the output register is empty or being drained,
// so a stalled response holds at most one request in flight behind it.
// Reset is synchronous and clears the parse state but the stored entity characters, and both valid flags.
module markup_tag_stripper_unit (
   input logic       clock,
   input logic       reset,
   mts_req_if.sink   req_bus,
   mts_rsp_if.source rsp_bus
);
   import mts_pkg::*;

   logic       s1_valid_ff, s1_valid_in;
   logic       s1_sot_ff;
   logic [7:0] s1_byte_ff;
   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] rsp_byte_ff;

   logic          out_free;
   logic          step;
   logic          req_take;
   mts_token_type token;
   mts_char_type  result;

   assign out_free    = !rsp_valid_ff || rsp_bus.ready;
   assign step        = s1_valid_ff && out_free;
   assign req_bus.ready = !s1_valid_ff || out_free;
   assign req_take    = req_bus.valid && req_bus.ready;
   assign s1_valid_in = req_take ? 1'b1 : (step ? 1'b0 : s1_valid_ff);
   assign rsp_valid_in = out_free ? (step && result.valid) : rsp_valid_ff;

   mts_parse u_parse (
      .clock         (clock),
      .reset         (reset),
      .step          (step),
      .start_of_text (s1_sot_ff),
      .in_byte       (s1_byte_ff),
      .token         (token)
   );

   mts_collapse u_collapse (
      .clock  (clock),
      .reset  (reset),
      .step   (step),
      .token  (token),
      .result (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_sot_ff  <= req_bus.start_of_text;
         s1_byte_ff <= req_bus.in_byte;
      end
      if (out_free && step && result.valid) begin
         rsp_byte_ff <= result.ch;
      end
   end

   assign rsp_bus.valid    = rsp_valid_ff;
   assign rsp_bus.out_byte = rsp_byte_ff;

endmodule
